// ===== rtl/pcmdm_pkg.sv =====
package pcmdm_pkg;

  // Fixed widths of the sample path
  localparam int unsigned SampleW = 16;
  localparam int unsigned CodeW   = 14;
  localparam int unsigned CountW  = 4;
  localparam int unsigned RemW    = 4;

  // Register indexes on the configuration port
  localparam logic RegFormat   = 1'b0;
  localparam logic RegChannels = 1'b1;

  // Sample format codes
  localparam logic FmtU8  = 1'b0;
  localparam logic FmtS16 = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC
  } pcmdm_state_e;

  // Settings the datapath works with
  typedef struct packed {
    logic              fmt;
    logic [CountW-1:0] chans;
  } pcmdm_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic acc;
  } pcmdm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic frame_done;
  } pcmdm_status_t;

endpackage

// ===== rtl/pcm_downmix_to_dac_top.sv =====
// PCM channel downmix to DAC code.
// Input channel: sample_word_i with sample_word_valid_i / sample_word_ready_o
// carries interleaved channel samples, one per transaction. Output channel:
// dac_code_o with dac_code_valid_o / dac_code_ready_i carries one 14-bit code
// per completed frame of channel_count samples.
// Each sample goes from acceptance to the next ready through an accept step,
// a one-bit-per-cycle restoring divider, and a step that adds the term to the
// frame sum; that last step can hold, as below. The code of a frame is
// registered in the accumulate step after its last sample finishes dividing.
// A finished code waits in an output register; a new sample is accepted while
// it waits. If the receiver stalls and the next frame completes, the block
// holds in its accumulate step until the waiting code has been taken.
// Configuration: APB, sample_format at 0x0 (reset 1), channel_count at 0x4
// (reset 1, zero is taken as one channel, saturated to MAX_CHANNELS). Write only
// while idle. Reset clears the frame sum, the channel index and the output valid.
module pcm_downmix_to_dac_top
  import pcmdm_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic [SampleW-1:0] sample_word_i,
  input  logic               sample_word_valid_i,
  output logic               sample_word_ready_o,
  output logic [CodeW-1:0]   dac_code_o,
  output logic               dac_code_valid_o,
  input  logic               dac_code_ready_i
);

  logic              fmt_q;
  logic [CountW-1:0] chans_q;
  logic              wr_en;
  logic [CountW-1:0] chans_eff;
  pcmdm_cfg_t        cfg;
  pcmdm_cmd_t        cmd;
  pcmdm_status_t     status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes, decoded on the word address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FmtS16;
      chans_q <= 4'd1;
    end else if (wr_en) begin
      case (paddr[2])
        RegFormat:   fmt_q   <= pwdata[0];
        RegChannels: chans_q <= pwdata[CountW-1:0];
        default:     fmt_q   <= fmt_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      RegFormat:   prdata = {31'd0, fmt_q};
      RegChannels: prdata = {28'd0, chans_q};
      default:     prdata = '0;
    endcase
  end

  // Clamp the channel count into one to MAX_CHANNELS
  always_comb begin
    chans_eff = chans_q;
    if (chans_q == '0) chans_eff = 4'd1;
    if (32'(chans_q) > MAX_CHANNELS) chans_eff = CountW'(MAX_CHANNELS);
  end

  assign cfg.fmt   = fmt_q;
  assign cfg.chans = chans_eff;

  pcmdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_word_valid_i),
    .in_ready_o  (sample_word_ready_o),
    .out_valid_o (dac_code_valid_o),
    .out_ready_i (dac_code_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcmdm_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (sample_word_i),
    .cmd_i    (cmd),
    .status_o (status),
    .code_o   (dac_code_o)
  );

  // A new code only comes out of an accumulate step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dac_code_valid_o) |-> $past(cmd.acc))
    else $error("output valid rose without an accumulate step");

  // An accepted sample keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_word_valid_i && sample_word_ready_o |=> !sample_word_ready_o)
    else $error("ready stayed high after an accepted sample");

  // Load, divide and accumulate never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.step, cmd.acc}))
    else $error("overlapping datapath commands");

  // The divider runs only while no sample is being accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !sample_word_ready_o)
    else $error("divider stepped while ready");

endmodule

// ===== rtl/pcmdm_ctrl.sv =====
module pcmdm_ctrl
  import pcmdm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pcmdm_status_t status_i,
  output pcmdm_cmd_t    cmd_o
);

  pcmdm_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         acc_go;

  // Accumulate unless a finished frame would overwrite a waiting result
  assign acc_go = !status_i.frame_done || !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (acc_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
      end
      ST_ACC: begin
        cmd_o.acc = acc_go;
        if (acc_go && status_i.frame_done) out_valid_d = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/pcmdm_datapath.sv =====
module pcmdm_datapath
  import pcmdm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcmdm_cfg_t         cfg_i,
  input  logic [SampleW-1:0] sample_i,
  input  pcmdm_cmd_t         cmd_i,
  output pcmdm_status_t      status_o,
  output logic [CodeW-1:0]   code_o
);

  logic [SampleW-1:0] dq_q;      // dividend shifting out, quotient shifting in
  logic [RemW-1:0]    rem_q;
  logic [CountW-1:0]  bit_q;
  logic [SampleW-1:0] sum_q, sum_d;
  logic [CountW-1:0]  idx_q;
  logic [CodeW-1:0]   code_q;

  logic [SampleW-1:0] dividend;
  logic [RemW:0]      trial;
  logic [RemW:0]      trial_sub;
  logic               qbit;
  logic [SampleW-1:0] term;
  logic [CountW:0]    idx_next;

  // Offset a signed sample to unsigned, or take the low byte
  assign dividend = (cfg_i.fmt == FmtU8) ? {8'h00, sample_i[7:0]}
                                         : (sample_i ^ 16'h8000);

  // One restoring division step
  assign trial     = {rem_q, dq_q[SampleW-1]};
  assign trial_sub = trial - {1'b0, cfg_i.chans};
  assign qbit      = (trial >= {1'b0, cfg_i.chans});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dq_q  <= dividend;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      dq_q  <= {dq_q[SampleW-2:0], qbit};
      rem_q <= qbit ? trial_sub[RemW-1:0] : trial[RemW-1:0];
    end
  end

  // Count division steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.load) begin
      bit_q <= '0;
    end else if (cmd_i.step) begin
      bit_q <= bit_q + 1'b1;
    end
  end

  assign status_o.div_last = (bit_q == {CountW{1'b1}});

  // Scale the quotient and add it to the frame sum
  assign term     = (cfg_i.fmt == FmtU8) ? {dq_q[7:0], 8'h00} : dq_q;
  assign sum_d    = sum_q + term;
  assign idx_next = {1'b0, idx_q} + 1'b1;

  assign status_o.frame_done = (idx_next >= {1'b0, cfg_i.chans});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.acc) begin
      if (status_o.frame_done) begin
        sum_q <= '0;
        idx_q <= '0;
      end else begin
        sum_q <= sum_d;
        idx_q <= idx_next[CountW-1:0];
      end
    end
  end

  // Hold the finished frame code for the output transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && status_o.frame_done) code_q <= sum_d[SampleW-1:2];
  end

  assign code_o = code_q;

endmodule
